// ----- rtl/gfb_pkg.sv -----
// Shared types and constants of the grayscale frame buffer.
package gfb_pkg;

  localparam int GEO_W       = 9;
  localparam int PROD_W      = 2 * GEO_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_PLOT = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_FILL = 2'd2;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    K_WRITE,
    K_RMW_LO,
    K_RMW_HI,
    K_READ8,
    K_READ_LO,
    K_READ_HI,
    K_READ_ZERO,
    K_FILL
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic             pixel_format;
    logic [GEO_W-1:0] image_width;
    logic [GEO_W-1:0] image_height;
  } cfg_t;

endpackage

// ----- rtl/gfb_ram.sv -----
// Generic simple dual-port RAM with registered read.
module gfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gfb_front.sv -----
// Front end: accepts items, classifies them and computes store addresses.
module gfb_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [15:0]         x_coord,
  input  logic [15:0]         y_coord,
  input  logic [31:0]         colour_word,
  input  gfb_pkg::cfg_t       cfg,
  input  logic                clearing,
  input  logic                q_full,
  output logic                push,
  output gfb_pkg::cmd_t       push_cmd,
  output logic [ADDR_W-1:0]   push_addr
);

  localparam int GW = gfb_pkg::GEO_W;
  localparam int PW = gfb_pkg::PROD_W;

  logic          a_valid;
  gfb_pkg::cmd_t a_cmd;
  logic [GW-1:0] a_mul;
  logic [GW-1:0] a_row;
  logic [GW-1:0] a_add;

  logic          accept;
  logic          keep;
  gfb_pkg::cmd_t cmd_next;
  logic [GW-1:0] mul_next;
  logic [GW-1:0] add_next;
  logic [GW-1:0] w_sat;
  logic [GW-1:0] h_sat;
  logic [GW-1:0] w;
  logic [GW-1:0] h;
  logic [GW-1:0] row;
  logic          empty;
  logic          in_range;
  logic [GW-1:0] xc;
  logic [GW-1:0] yc;
  logic [7:0]    g8;
  logic [3:0]    g4;
  logic [PW-1:0] prod;

  assign busy   = clearing || (a_valid && q_full);
  assign accept = start && !busy;

  assign w_sat = (32'(cfg.image_width) > MAX_WIDTH) ? GW'(MAX_WIDTH) : cfg.image_width;
  assign h_sat = (32'(cfg.image_height) > MAX_HEIGHT) ? GW'(MAX_HEIGHT) : cfg.image_height;
  assign w     = {w_sat[GW-1:1], 1'b0};
  assign h     = h_sat;
  assign row   = cfg.pixel_format ? {1'b0, w[GW-1:1]} : w;
  assign empty = (w == '0) || (h == '0);

  assign in_range = ({{(16-GW){1'b0}}, w} > x_coord) && ({{(16-GW){1'b0}}, h} > y_coord);
  assign xc = (x_coord >= {{(16-GW){1'b0}}, w}) ? w - GW'(1) : x_coord[GW-1:0];
  assign yc = (y_coord >= {{(16-GW){1'b0}}, h}) ? h - GW'(1) : y_coord[GW-1:0];

  assign g8 = colour_word[15:8];
  assign g4 = colour_word[15:12];

  always_comb begin
    keep           = 1'b0;
    cmd_next.kind  = gfb_pkg::K_WRITE;
    cmd_next.value = g8;
    mul_next       = '0;
    add_next       = '0;
    case (opcode)
      gfb_pkg::OP_PLOT: begin
        keep     = in_range;
        mul_next = y_coord[GW-1:0];
        if (cfg.pixel_format) begin
          cmd_next.kind  = x_coord[0] ? gfb_pkg::K_RMW_HI : gfb_pkg::K_RMW_LO;
          cmd_next.value = {4'h0, g4};
          add_next       = {1'b0, x_coord[GW-1:1]};
        end else begin
          add_next = x_coord[GW-1:0];
        end
      end
      gfb_pkg::OP_READ: begin
        keep = 1'b1;
        if (empty) begin
          cmd_next.kind = gfb_pkg::K_READ_ZERO;
        end else if (cfg.pixel_format) begin
          cmd_next.kind = xc[0] ? gfb_pkg::K_READ_HI : gfb_pkg::K_READ_LO;
          mul_next      = yc;
          add_next      = {1'b0, xc[GW-1:1]};
        end else begin
          cmd_next.kind = gfb_pkg::K_READ8;
          mul_next      = yc;
          add_next      = xc;
        end
      end
      gfb_pkg::OP_FILL: begin
        keep           = !empty;
        cmd_next.kind  = gfb_pkg::K_FILL;
        cmd_next.value = cfg.pixel_format ? {g4, g4} : g8;
        mul_next       = h - GW'(1);
        add_next       = row - GW'(1);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= keep;
    end else if (push) begin
      a_valid <= 1'b0;
    end
    if (accept) begin
      a_cmd <= cmd_next;
      a_mul <= mul_next;
      a_row <= row;
      a_add <= add_next;
    end
  end

  assign prod      = PW'(a_mul) * PW'(a_row) + PW'(a_add);
  assign push      = a_valid && !q_full;
  assign push_cmd  = a_cmd;
  assign push_addr = ADDR_W'(prod);

endmodule

// ----- rtl/gfb_queue.sv -----
// Small register FIFO between the front and back ends.
module gfb_queue #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/gfb_back.sv -----
// Back end: executes writes, nibble updates, reads and fill walks on the store.
module gfb_back #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  gfb_pkg::cmd_t            head_cmd,
  input  logic [$clog2(DEPTH)-1:0] head_addr,
  output logic                     pop,
  output logic                     clearing,
  output logic                     result_valid,
  output logic [23:0]              pixel_rgb,
  output logic [7:0]               gray_level
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [1:0] {RUN, RMW, WALK} state_t;

  state_t          state;
  logic [AW-1:0]   walk_addr;
  logic [AW-1:0]   walk_last;
  logic [7:0]      walk_val;
  logic [AW-1:0]   hold_addr;
  logic [3:0]      hold_nib;
  logic            hold_hi;
  logic            rd_pend;
  gfb_pkg::kind_t  rd_kind;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic [7:0]      g;

  gfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_addr),
    .rdata (ram_rdata)
  );

  assign pop = (state == RUN) && !q_empty;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_addr;
    ram_wdata = head_cmd.value;
    case (state)
      RUN: begin
        ram_we = pop && (head_cmd.kind == gfb_pkg::K_WRITE);
      end
      RMW: begin
        ram_we    = 1'b1;
        ram_waddr = hold_addr;
        ram_wdata = hold_hi ? {hold_nib, ram_rdata[3:0]} : {ram_rdata[7:4], hold_nib};
      end
      WALK: begin
        ram_we    = 1'b1;
        ram_waddr = walk_addr;
        ram_wdata = walk_val;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (rd_kind)
      gfb_pkg::K_READ8:   g = ram_rdata;
      gfb_pkg::K_READ_LO: g = {ram_rdata[3:0], ram_rdata[3:0]};
      gfb_pkg::K_READ_HI: g = {ram_rdata[7:4], ram_rdata[7:4]};
      default:            g = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= WALK;
      walk_addr    <= '0;
      walk_last    <= LAST_ADDR;
      walk_val     <= 8'h00;
      clearing     <= 1'b1;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_pend;
      gray_level   <= g;
      pixel_rgb    <= {g, g, g};
      rd_pend      <= 1'b0;
      case (state)
        RUN: begin
          if (pop) begin
            case (head_cmd.kind)
              gfb_pkg::K_RMW_LO, gfb_pkg::K_RMW_HI: begin
                hold_addr <= head_addr;
                hold_nib  <= head_cmd.value[3:0];
                hold_hi   <= (head_cmd.kind == gfb_pkg::K_RMW_HI);
                state     <= RMW;
              end
              gfb_pkg::K_READ8, gfb_pkg::K_READ_LO, gfb_pkg::K_READ_HI,
              gfb_pkg::K_READ_ZERO: begin
                rd_pend <= 1'b1;
                rd_kind <= head_cmd.kind;
              end
              gfb_pkg::K_FILL: begin
                walk_addr <= '0;
                walk_last <= head_addr;
                walk_val  <= head_cmd.value;
                state     <= WALK;
              end
              default: begin
                state <= RUN;
              end
            endcase
          end
        end
        RMW: begin
          state <= RUN;
        end
        WALK: begin
          if (walk_addr == walk_last) begin
            clearing <= 1'b0;
            state    <= RUN;
          end else begin
            walk_addr <= walk_addr + AW'(1);
          end
        end
        default: begin
          state <= RUN;
        end
      endcase
    end
  end

endmodule

// ----- rtl/grayscale_framebuffer.sv -----
// Top level of the grayscale frame buffer with 8-bit or packed 4-bit pixels.
//
//   channel   handshake             payload
//   command   start / busy          opcode, x_coord, y_coord, colour_word
//   result    result_valid strobe   pixel_rgb, gray_level
//   config    cfg_we                cfg_index, cfg_data
//
// 8-bit plots and reads use the store once each; a 4-bit plot does a nibble read,
// then a write on the same store ports. A fill writes W*H store bytes (W*H/2 in
// 4-bit mode): a dispatch step, then one store byte per cycle. After reset a clearing
// pass over all MAX_WIDTH*MAX_HEIGHT store bytes zeroes the store with busy high.
// The result channel has no stall: each result stands for one cycle.
module grayscale_framebuffer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] x_coord,
  input  logic [15:0] y_coord,
  input  logic [31:0] colour_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output logic        result_valid,
  output logic [23:0] pixel_rgb,
  output logic [7:0]  gray_level
);

  localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CMD_W       = $bits(gfb_pkg::cmd_t);
  localparam int ENTRY_W     = CMD_W + ADDR_W;

  gfb_pkg::cfg_t       cfg;
  logic                clearing;
  logic                q_full;
  logic                q_empty;
  logic                push;
  logic                pop;
  gfb_pkg::cmd_t       push_cmd;
  logic [ADDR_W-1:0]   push_addr;
  logic [ENTRY_W-1:0]  head;
  gfb_pkg::cmd_t       head_cmd;
  logic [ADDR_W-1:0]   head_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= 1'b0;
      cfg.image_width  <= 9'd256;
      cfg.image_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        gfb_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[0];
        gfb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        gfb_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default:                   cfg <= cfg;
      endcase
    end
  end

  gfb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .colour_word (colour_word),
    .cfg         (cfg),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_addr   (push_addr)
  );

  gfb_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (gfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cmd, push_addr}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  assign head_cmd  = gfb_pkg::cmd_t'(head[ENTRY_W-1:ADDR_W]);
  assign head_addr = head[ADDR_W-1:0];

  gfb_back #(
    .DEPTH (STORE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head_cmd     (head_cmd),
    .head_addr    (head_addr),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .pixel_rgb    (pixel_rgb),
    .gray_level   (gray_level)
  );

endmodule

// ----- dv/grayscale_framebuffer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the grayscale frame buffer: plots, clamped reads and fills.
module grayscale_framebuffer_tb;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int STORE_BYTES = MAX_W * MAX_H;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int FILL_BUDGET = 250000;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 108;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] colour;
  } draw_cmd_t;

  typedef struct {
    logic [23:0] rgb;
    logic [7:0]  gray;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = gfb_pkg::OP_PLOT;
  logic [15:0] x_coord = '0;
  logic [15:0] y_coord = '0;
  logic [31:0] colour_word = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gfb_pkg::REG_PIXEL_FORMAT;
  logic [8:0]  cfg_data = '0;
  logic        result_valid;
  logic [23:0] pixel_rgb;
  logic [7:0]  gray_level;

  grayscale_framebuffer #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .colour_word (colour_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .pixel_rgb   (pixel_rgb),
    .gray_level  (gray_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] mirror_store [STORE_BYTES];
  logic       mirror_fmt = 1'b0;
  logic [8:0] mirror_width = 9'd256;
  logic [8:0] mirror_height = 9'd256;

  draw_cmd_t pending_cmds[$];
  shade_t    gray_due[$];
  draw_cmd_t on_port;
  int        burst_left = 1;
  int        gap_left = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        fill_spend = 0;

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) mirror_store[i] = 8'h00;
  end

  function automatic int span_width();
    int w;
    w = (mirror_width > MAX_W) ? MAX_W : int'(mirror_width);
    return w - (w % 2);
  endfunction

  function automatic int span_height();
    return (mirror_height > MAX_H) ? MAX_H : int'(mirror_height);
  endfunction

  function automatic int byte_index(int x, int y, int w);
    if (mirror_fmt) return (y * (w / 2) + x / 2) % STORE_BYTES;
    return (y * w + x) % STORE_BYTES;
  endfunction

  // Update the mirrored store for one accepted command; queue the read result.
  function automatic void trace_command(draw_cmd_t c);
    int w, h, xi, yi, a, n;
    logic [7:0] g8, v, b;
    logic [3:0] g4;
    int g;
    shade_t s;
    w = span_width();
    h = span_height();
    xi = int'(c.x);
    yi = int'(c.y);
    g8 = c.colour[15:8];
    g4 = g8[7:4];
    case (c.op)
      gfb_pkg::OP_PLOT: begin
        if (xi < w && yi < h) begin
          a = byte_index(xi, yi, w);
          if (!mirror_fmt) mirror_store[a] = g8;
          else if (xi % 2 == 0) mirror_store[a] = {mirror_store[a][7:4], g4};
          else mirror_store[a] = {g4, mirror_store[a][3:0]};
        end
      end
      gfb_pkg::OP_READ: begin
        g = 0;
        if (w != 0 && h != 0) begin
          if (xi > w - 1) xi = w - 1;
          if (yi > h - 1) yi = h - 1;
          b = mirror_store[byte_index(xi, yi, w)];
          if (!mirror_fmt) g = int'(b);
          else if (xi % 2 == 0) g = int'(b[3:0]) * 17;
          else g = int'(b[7:4]) * 17;
        end
        s.gray = g[7:0];
        s.rgb = {g[7:0], g[7:0], g[7:0]};
        gray_due.push_back(s);
      end
      gfb_pkg::OP_FILL: begin
        n = w * h;
        if (mirror_fmt) begin
          n = n / 2;
          v = {g4, g4};
        end else begin
          v = g8;
        end
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (int i = 0; i < n; i++) mirror_store[i] = v;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("grayscale_framebuffer test failed");
      $finish;
    end
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) trace_command(on_port);
      if (start && busy) begin
        // hold the command until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        on_port = pending_cmds.pop_front();
        opcode <= on_port.op;
        x_coord <= on_port.x;
        y_coord <= on_port.y;
        colour_word <= on_port.colour;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result against the oldest pending read.
  always @(posedge clk) begin
    shade_t want;
    if (!rst && result_valid) begin
      if (gray_due.size() == 0) begin
        flag_mismatch("unexpected result", pixel_rgb, 24'h0);
      end else begin
        want = gray_due.pop_front();
        if (pixel_rgb !== want.rgb) flag_mismatch("pixel_rgb", pixel_rgb, want.rgb);
        if (gray_level !== want.gray) flag_mismatch("gray_level", {16'h0, gray_level},
                                                    {16'h0, want.gray});
      end
    end
  end

  task automatic put_cmd(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                         logic [31:0] colour);
    draw_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.colour = colour;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || busy || gray_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [8:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      gfb_pkg::REG_PIXEL_FORMAT: mirror_fmt = data[0];
      gfb_pkg::REG_IMAGE_WIDTH: mirror_width = data;
      gfb_pkg::REG_IMAGE_HEIGHT: mirror_height = data;
      default: begin
      end
    endcase
  endtask

  task automatic set_geometry(logic fmt, int w, int h);
    wait_drained();
    set_reg(gfb_pkg::REG_PIXEL_FORMAT, {8'($urandom_range(0, 255)), fmt});
    set_reg(gfb_pkg::REG_IMAGE_WIDTH, w[8:0]);
    set_reg(gfb_pkg::REG_IMAGE_HEIGHT, h[8:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_spot(output logic [15:0] x, output logic [15:0] y, input int w,
                           input int h);
    int r;
    r = $urandom_range(0, 99);
    if (w > 0 && h > 0 && r < 80) begin
      x = 16'($urandom_range(0, w - 1));
      y = 16'($urandom_range(0, h - 1));
    end else if (r < 90) begin
      x = 16'(w + $urandom_range(0, 2));
      y = 16'((h > 0) ? $urandom_range(0, h - 1) : $urandom_range(0, 2));
      if ($urandom_range(0, 1)) begin
        y = 16'(h + $urandom_range(0, 2));
        x = 16'((w > 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 2));
      end
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
  endtask

  // Mostly plots and reads, many reads at or beside recently plotted spots; some fills and noise.
  task automatic queue_random_phase(int count);
    int w, h, bytes, fills, pick, k;
    logic [15:0] px[$];
    logic [15:0] py[$];
    draw_cmd_t c;
    w = span_width();
    h = span_height();
    bytes = mirror_fmt ? (w * h) / 2 : w * h;
    fills = 0;
    for (int i = 0; i < count; i++) begin
      c.colour = $urandom;
      pick = $urandom_range(0, 99);
      pick_spot(c.x, c.y, w, h);
      if (pick < 3 && fills < 3 && fill_spend + bytes <= FILL_BUDGET) begin
        c.op = gfb_pkg::OP_FILL;
        fills++;
        fill_spend += bytes;
      end else if (pick < 8) begin
        c.op = OP_NONE;
      end else if (pick < 52) begin
        c.op = gfb_pkg::OP_PLOT;
        px.push_back(c.x);
        py.push_back(c.y);
        if (px.size() > 16) begin
          void'(px.pop_front());
          void'(py.pop_front());
        end
      end else begin
        c.op = gfb_pkg::OP_READ;
        if (px.size() > 0 && $urandom_range(0, 1)) begin
          k = $urandom_range(0, px.size() - 1);
          c.x = px[k] ^ 16'($urandom_range(0, 1));
          c.y = py[k];
        end
      end
      if (i == count - 1) c.op = gfb_pkg::OP_READ;
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    int w, h;
    logic fmt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_cmd(gfb_pkg::OP_READ, 16'd0, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_PLOT, 16'd0, 16'd0, 32'hFFFF_FFFF);
    put_cmd(gfb_pkg::OP_PLOT, 16'd255, 16'd255, 32'h0000_AB00);
    put_cmd(gfb_pkg::OP_PLOT, 16'd256, 16'd0, 32'h0000_1200);
    put_cmd(gfb_pkg::OP_PLOT, 16'd0, 16'd256, 32'h0000_3400);
    put_cmd(gfb_pkg::OP_PLOT, 16'hFFFF, 16'hFFFF, 32'h0000_5600);
    put_cmd(OP_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    put_cmd(gfb_pkg::OP_READ, 16'd0, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    put_cmd(gfb_pkg::OP_FILL, 16'd0, 16'd0, 32'h0000_5A00);
    put_cmd(gfb_pkg::OP_READ, 16'd100, 16'd100, 32'h0);

    set_geometry(1'b1, 256, 256);
    put_cmd(gfb_pkg::OP_READ, 16'd0, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_READ, 16'd1, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_PLOT, 16'd0, 16'd0, 32'h0000_F000);
    put_cmd(gfb_pkg::OP_PLOT, 16'd1, 16'd0, 32'h0000_3F00);
    put_cmd(gfb_pkg::OP_READ, 16'd0, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_READ, 16'd1, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_FILL, 16'd0, 16'd0, 32'hFFFF_C3FF);
    put_cmd(gfb_pkg::OP_READ, 16'd300, 16'd2, 32'h0);

    set_geometry(1'b0, 1, 7);
    put_cmd(gfb_pkg::OP_PLOT, 16'd0, 16'd0, 32'h0000_7700);
    put_cmd(gfb_pkg::OP_READ, 16'd0, 16'd0, 32'h0);
    put_cmd(gfb_pkg::OP_FILL, 16'd0, 16'd0, 32'h0000_9900);
    put_cmd(gfb_pkg::OP_READ, 16'd3, 16'd3, 32'h0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fmt = p[0];
      case (p)
        0: begin w = 2; h = 1; end
        1: begin w = 511; h = 511; end
        2: begin w = $urandom_range(0, 1); h = $urandom_range(0, 511); end
        3: begin w = $urandom_range(2, 511); h = 0; end
        4: begin w = 256; h = 256; end
        5: begin w = 257; h = $urandom_range(1, 8); end
        default: begin
          fmt = $urandom_range(0, 1);
          if ($urandom_range(0, 1)) begin
            w = $urandom_range(2, 48);
            h = $urandom_range(1, 48);
          end else begin
            w = $urandom_range(0, 511);
            h = $urandom_range(0, 511);
          end
        end
      endcase
      set_geometry(fmt, w, h);
      queue_random_phase(PHASE_ITEMS);
    end

    wait_drained();
    if (mismatch_count == 0) $display("grayscale_framebuffer test passed");
    else $display("grayscale_framebuffer test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gfb_pkg.sv
rtl/gfb_ram.sv
rtl/gfb_front.sv
rtl/gfb_queue.sv
rtl/gfb_back.sv
rtl/grayscale_framebuffer.sv
dv/grayscale_framebuffer_tb.sv
